// ===== hw/rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg - shared types and constants of the sliding window maximum filter
// Sample type, register map and the broadcast bundle fed to every cell.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int WIN_W      = 7;
	localparam int CFG_ADDR_W = 3;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_WINDOW_SIZE = 1'b0
	} reg_idx_t;

	localparam logic [WIN_W-1:0] WINDOW_SIZE_RESET = 7'd3;

	// broadcast to all cells on a sample transfer
	typedef struct packed {
		logic    en;
		logic    start;
		sample_t sample;
	} swm_bcast_t;

endpackage

// ===== hw/rtl/swm_if.sv =====
// ----------------------------------------------------------------------------
// swm_if - stream channels of the sliding window maximum filter
// Valid/ready channels for input samples and for window maxima.
// ----------------------------------------------------------------------------
interface swm_sample_if import swm_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    starts_sequence;

	modport source (output valid, output sample, output starts_sequence, input ready);
	modport sink (input valid, input sample, input starts_sequence, output ready);
endinterface

interface swm_result_if import swm_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t window_max;

	modport source (output valid, output window_max, input ready);
	modport sink (input valid, input window_max, output ready);
endinterface

// ===== hw/rtl/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell - one cell of the running maximum chain
// Cell k holds the max of the last k+1 samples: max(new sample, left cell).
// ----------------------------------------------------------------------------
module swm_cell import swm_pkg::*; (
	input  logic       clk,
	input  swm_bcast_t bc,
	input  sample_t    prev,
	output sample_t    nxt,
	output sample_t    val
);

	sample_t val_q;

	// start of sequence: left neighbor holds old data, drop it
	always_comb begin
		if (bc.start || (prev <= bc.sample)) begin
			nxt = bc.sample;
		end else begin
			nxt = prev;
		end
	end

	always_ff @(posedge clk) begin
		if (bc.en) begin
			val_q <= nxt;
		end
	end

	assign val = val_q;

endmodule

// ===== hw/rtl/swm_skid.sv =====
// ----------------------------------------------------------------------------
// swm_skid - two-entry output buffer
// Main register drives the port; skid entry catches a result on a stall.
// ----------------------------------------------------------------------------
module swm_skid import swm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  sample_t push_data,
	output logic    push_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output sample_t out_data
);

	logic    main_v_q;
	logic    skid_v_q;
	sample_t main_q;
	sample_t skid_q;
	logic    pop;

	assign pop        = main_v_q && out_ready;
	assign push_ready = !skid_v_q;
	assign out_valid  = main_v_q;
	assign out_data   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			if (main_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_v_q) begin
			main_q <= skid_q;
		end else if (push && (pop || !main_v_q)) begin
			main_q <= push_data;
		end
		if (push && main_v_q && !pop) begin
			skid_q <= push_data;
		end
	end

	// skid entry only fills behind a held main entry
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid entry valid with empty main entry");

	// a held result is only dropped when taken
	a_main_drop_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(main_v_q) |-> $past(out_ready))
		else $error("result dropped without transfer");

	// a full skid entry stays full until the main entry is taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !pop |=> skid_v_q)
		else $error("skid entry lost");

endmodule

// ===== hw/rtl/sliding_window_maximum_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_maximum_top - sliding window maximum filter
// Takes one signed 32-bit sample per transfer and returns the largest of the
// last window_size samples once that many samples of the current sequence
// have arrived; a sample with starts_sequence set opens a new sequence. The
// filter takes one sample per clock while the input is not stalled: the
// work is a row of MAX_WINDOW cells in which cell k keeps the maximum of
// the last k+1 samples, so each sample costs one compare per cell, all in
// parallel. A result is registered into the output buffer on its sample
// transfer. A second output entry lets one more result land while the sink
// stalls; the input stalls only when both entries are full. window_size
// (register 0, byte address 0) is 7 bits; 0 acts as 1, values above
// MAX_WINDOW act as MAX_WINDOW. Write it only while no sample is in flight.
// ----------------------------------------------------------------------------
module sliding_window_maximum_top import swm_pkg::*; #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	swm_sample_if.sink            samples,
	swm_result_if.source          results,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int SEEN_W = $clog2(MAX_WINDOW + 1);
	localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int EXT_W  = (SEEN_W > WIN_W) ? SEEN_W : WIN_W;

	// ---- configuration ---------------------------------------------------
	logic [WIN_W-1:0] window_size_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && (cfg_idx == REG_WINDOW_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_SIZE_RESET;
		end else if (cfg_wr) begin
			window_size_q <= pwdata[WIN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_WINDOW_SIZE: prdata = {{(32-WIN_W){1'b0}}, window_size_q};
			default:         prdata = '0;
		endcase
	end

	// effective window: zero reads as one, clamp to the cell count
	logic [EXT_W-1:0]  win_ext;
	logic [SEEN_W-1:0] eff_win;
	logic [IDX_W-1:0]  tap_sel;

	always_comb begin
		win_ext = EXT_W'(window_size_q);
		if (win_ext == '0) begin
			win_ext = EXT_W'(1);
		end
		if (win_ext > EXT_W'(MAX_WINDOW)) begin
			win_ext = EXT_W'(MAX_WINDOW);
		end
		eff_win = SEEN_W'(win_ext);
		tap_sel = IDX_W'(eff_win - SEEN_W'(1));
	end

	// ---- sample transfer and sequence count -------------------------------
	logic              acc;
	logic              push_ready;
	logic [SEEN_W-1:0] seen_q;
	logic [SEEN_W-1:0] seen_nxt;
	logic              emit;
	swm_bcast_t        bc;

	assign samples.ready = push_ready;
	assign acc           = samples.valid && push_ready;

	assign bc.en     = acc;
	assign bc.start  = samples.starts_sequence;
	assign bc.sample = samples.sample;

	// saturating count of samples in the current sequence
	always_comb begin
		if (samples.starts_sequence) begin
			seen_nxt = SEEN_W'(1);
		end else if (seen_q < SEEN_W'(MAX_WINDOW)) begin
			seen_nxt = seen_q + SEEN_W'(1);
		end else begin
			seen_nxt = seen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (acc) begin
			seen_q <= seen_nxt;
		end
	end

	assign emit = seen_nxt >= eff_win;

	// ---- cell chain -------------------------------------------------------
	// cell k: max of last k+1 samples; cell 0 just takes the sample
	sample_t cell_val [MAX_WINDOW];
	sample_t cell_nxt [MAX_WINDOW];

	for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
		sample_t prev;
		if (k == 0) begin : g_first
			assign prev = samples.sample;
		end else begin : g_rest
			assign prev = cell_val[k-1];
		end
		swm_cell u_cell (
			.clk  (clk),
			.bc   (bc),
			.prev (prev),
			.nxt  (cell_nxt[k]),
			.val  (cell_val[k])
		);
	end

	// the new value of cell window-1 is this sample's result
	sample_t result;
	assign result = cell_nxt[tap_sel];

	// ---- output buffer ----------------------------------------------------
	swm_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (acc && emit),
		.push_data  (result),
		.push_ready (push_ready),
		.out_valid  (results.valid),
		.out_ready  (results.ready),
		.out_data   (results.window_max)
	);

	// ---- checks -----------------------------------------------------------
	a_seen_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= SEEN_W'(MAX_WINDOW))
		else $error("sequence count past cell count");

	a_start_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		acc && samples.starts_sequence |=> seen_q == SEEN_W'(1))
		else $error("sequence start did not restart count");

	a_full_window_emits: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (seen_q == SEEN_W'(MAX_WINDOW)) && !samples.starts_sequence
		|=> results.valid)
		else $error("full window gave no result");

endmodule

// ===== tb/sliding_window_maximum_top_tb.sv =====
// ----------------------------------------------------------------------------
// sliding_window_maximum_top_tb - self-checking bench of the window maximum
// Streams signed samples through the filter with random bursts, gaps and
// output stalls, tracks the window in a local shadow and checks every maximum
// in order. window_size is reprogrammed between phases over the APB port.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sliding_window_maximum_top_tb import swm_pkg::*; ();

	localparam int MAX_WINDOW     = 64;
	localparam int RANDOM_ITEMS   = 1000;
	localparam int HOLD_CYCLES    = 300;    // long output hold-off
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transfer at all

	// register map: one register at index 0, index 1 holds nothing
	localparam logic [CFG_ADDR_W-1:0] WINDOW_SIZE_ADDR = CFG_ADDR_W'(4 * int'(REG_WINDOW_SIZE));
	localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR       = CFG_ADDR_W'(4);

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef enum logic [1:0] {
		SINK_ALWAYS,
		SINK_PATTERN,
		SINK_SPARSE
	} sink_mode_t;

	typedef struct packed {
		logic    starts;
		sample_t sample;
	} win_item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	swm_sample_if samples_ch ();
	swm_result_if results_ch ();

	sliding_window_maximum_top #(
		.MAX_WINDOW (MAX_WINDOW)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow of the filter: ring of recent samples, sequence length and
	// the programmed window. Advanced once per accepted sample transfer.
	// ------------------------------------------------------------------
	sample_t          ring [MAX_WINDOW];
	int unsigned      seq_len;
	int unsigned      ring_wr;
	logic [WIN_W-1:0] win_cfg;

	sample_t          max_expected [$];   // window maxima still owed by the filter
	win_item_t        sample_queue [$];   // samples waiting for the driver
	int unsigned      items_queued;
	int unsigned      items_sent;
	int unsigned      errors;

	// 0 acts as 1, anything past the ring depth acts as the full ring
	function automatic int unsigned effective_span(input logic [WIN_W-1:0] win);
		if (win == '0)
			return 1;
		if (win > MAX_WINDOW)
			return MAX_WINDOW;
		return 32'(win);
	endfunction

	// Takes one sample; returns 1 and the window maximum once the sequence
	// covers the window. A start flag drops everything older first.
	function automatic bit predict_window_max(input sample_t s, input logic starts,
			output sample_t best);
		int unsigned span;
		int unsigned idx;
		if (starts)
			seq_len = 0;
		ring[ring_wr] = s;
		ring_wr = (ring_wr + 1 >= MAX_WINDOW) ? 0 : ring_wr + 1;
		if (seq_len < MAX_WINDOW)
			seq_len++;
		span = effective_span(win_cfg);
		best = s;
		if (seq_len < span)
			return 1'b0;
		// newest sample sits at ring_wr-1, walk back over the rest
		for (int unsigned i = 1; i < span; i++) begin
			idx = (ring_wr + MAX_WINDOW - 1 - i) % MAX_WINDOW;
			if (ring[idx] > best)
				best = ring[idx];
		end
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Driver: bursts of random length, random gaps between them. Pacing
	// knobs are set per phase by the stimulus block.
	// ------------------------------------------------------------------
	int unsigned src_burst_max;
	int unsigned src_gap_max;
	int unsigned burst_left;
	int unsigned gap_left;
	win_item_t   drv_item;
	sample_t     drv_best;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_ch.valid           <= 1'b0;
			samples_ch.sample          <= '0;
			samples_ch.starts_sequence <= 1'b0;
			items_sent                 <= 0;
			burst_left = 0;
			gap_left   = 0;
			seq_len    = 0;
			ring_wr    = 0;
		end else begin
			if (samples_ch.valid && samples_ch.ready) begin
				items_sent <= items_sent + 1;
				if (predict_window_max(samples_ch.sample, samples_ch.starts_sequence, drv_best))
					max_expected = {max_expected, drv_best};
			end
			// load the next sample only once the current one is gone
			if (!samples_ch.valid || samples_ch.ready) begin
				if (gap_left != 0 || sample_queue.size() == 0) begin
					if (gap_left != 0)
						gap_left--;
					samples_ch.valid <= 1'b0;
				end else begin
					drv_item = sample_queue.pop_front();
					samples_ch.valid           <= 1'b1;
					samples_ch.sample          <= drv_item.sample;
					samples_ch.starts_sequence <= drv_item.starts;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, src_burst_max);
						gap_left   = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result transfer against the oldest expected
	// maximum. Per sink mode, ready is high, follows a stall pattern or
	// is random. A stimulus hold request freezes ready for HOLD_CYCLES.
	// ------------------------------------------------------------------
	sink_mode_t  snk_mode;
	int unsigned hold_req;
	int unsigned hold_seen;
	int unsigned hold_left;
	logic [15:0] stall_pat;
	logic [5:0]  pat_age;
	logic        snk_rdy;
	sample_t     mon_want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_ch.ready <= 1'b0;
			hold_seen = 0;
			hold_left = 0;
			stall_pat = 16'hB5A3;
			pat_age   = '0;
		end else begin
			if (results_ch.valid && results_ch.ready) begin
				if (max_expected.size() == 0) begin
					$display("%0t: window_max expected none, actual %0d",
						$time, results_ch.window_max);
					errors++;
				end else begin
					mon_want = max_expected.pop_front();
					if (results_ch.window_max !== mon_want) begin
						$display("%0t: window_max expected %0d, actual %0d",
							$time, mon_want, results_ch.window_max);
						errors++;
					end
				end
			end
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				snk_rdy = 1'b0;
			end else begin
				case (snk_mode)
					SINK_ALWAYS: begin
						snk_rdy = 1'b1;
					end
					SINK_PATTERN: begin
						snk_rdy   = stall_pat[0];
						stall_pat = {stall_pat[0], stall_pat[15:1]};
						pat_age++;
						if (pat_age == '0)
							stall_pat = 16'($urandom) | 16'h0001;
					end
					default: begin
						snk_rdy = ($urandom_range(0, 2) == 0);
					end
				endcase
			end
			results_ch.ready <= snk_rdy;
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: ends the run after too long without any transfer.
	// ------------------------------------------------------------------
	int unsigned idle_cycles;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_item(input sample_t s, input logic starts);
		win_item_t it;
		it.sample = s;
		it.starts = starts;
		sample_queue = {sample_queue, it};
		items_queued++;
	endtask

	// wait until every queued sample is sent and every maximum has arrived,
	// then a few cycles more for a sample that yields no result
	task automatic drain();
		do
			@(posedge clk);
		while (sample_queue.size() != 0 || items_sent != items_queued
			|| max_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one APB transfer: setup cycle, then access until pready
	task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_window_reg();
		logic [31:0] rd;
		cfg_access(1'b0, WINDOW_SIZE_ADDR, '0, rd);
		if (rd[WIN_W-1:0] !== win_cfg) begin
			$display("%0t: window_size readback expected %0d, actual %0d",
				$time, win_cfg, rd[WIN_W-1:0]);
			errors++;
		end
	endtask

	// upper data bits are junk on purpose, only the low WIN_W bits count
	task automatic set_window(input logic [WIN_W-1:0] win);
		logic [31:0] wd;
		logic [31:0] rd;
		drain();
		wd = $urandom;
		wd[WIN_W-1:0] = win;
		cfg_access(1'b1, WINDOW_SIZE_ADDR, wd, rd);
		win_cfg = win;
		check_window_reg();
	endtask

	// mix of full-range values, a narrow band that breeds duplicates,
	// the extremes and single-bit patterns
	function automatic sample_t rand_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return sample_t'($urandom);
			4, 5, 6:    return sample_t'(int'($urandom_range(0, 16)) - 8);
			7:          return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
			8:          return $urandom_range(0, 1) ? SAMPLE_MAX - sample_t'($urandom_range(0, 3))
			                                        : SAMPLE_MIN + sample_t'($urandom_range(0, 3));
			default:    return $urandom_range(0, 1) ? sample_t'(32'h1 << $urandom_range(0, 31))
			                                        : ~sample_t'(32'h1 << $urandom_range(0, 31));
		endcase
	endfunction

	// Sequences start with a flag and run a bit past the window, so most
	// of them produce results; a stray flag now and then cuts one short.
	// With fresh cleared the phase carries on the previous sequence under
	// the new window size.
	task automatic run_phase(input logic [WIN_W-1:0] win, input bit fresh);
		int unsigned span;
		int unsigned seq_left;
		int unsigned n_items;
		logic        starts;
		set_window(win);
		span     = effective_span(win);
		n_items  = 2 * span + 40;
		seq_left = fresh ? 0 : span + 10;
		for (int unsigned k = 0; k < n_items; k++) begin
			starts = (seq_left == 0) || ($urandom_range(0, 79) == 0);
			if (starts)
				seq_left = span + $urandom_range(0, 40);
			seq_left--;
			push_item(rand_sample(), starts);
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	localparam logic [WIN_W-1:0] WIN_PLAN [10] = '{
		7'd64, 7'd1, 7'd127, 7'd2, 7'd17, 7'd0, 7'd100, 7'd5, 7'd33, 7'd3
	};

	int unsigned      phase;
	int unsigned      directed_items;
	logic [WIN_W-1:0] next_win;
	logic [31:0]      rd_word;

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		items_queued  = 0;
		errors        = 0;
		hold_req      = 0;
		src_burst_max = 8;
		src_gap_max   = 3;
		snk_mode      = SINK_PATTERN;
		win_cfg       = WINDOW_SIZE_RESET;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part, window at its reset value of 3 ---
		check_window_reg();
		// an extreme leaving the window, then a run of the other extreme
		push_item(SAMPLE_MAX, 1'b1);
		push_item(SAMPLE_MIN, 1'b0);
		push_item(SAMPLE_MIN, 1'b0);
		push_item(SAMPLE_MIN, 1'b0);
		// duplicates: one copy of 5 leaving must not drop the other
		push_item(sample_t'(5), 1'b0);
		push_item(sample_t'(5), 1'b0);
		push_item(sample_t'(3), 1'b0);
		push_item(sample_t'(3), 1'b0);
		push_item(sample_t'(3), 1'b0);
		// restart: the large value before the flag must never show up
		push_item(SAMPLE_MAX, 1'b1);
		push_item(SAMPLE_MIN, 1'b1);
		push_item(SAMPLE_MIN, 1'b0);
		push_item(SAMPLE_MIN, 1'b0);

		// write to the empty register slot is dropped
		drain();
		cfg_access(1'b1, SPARE_ADDR, 32'h1, rd_word);
		check_window_reg();

		// window of one: every sample is its own maximum
		set_window(7'd1);
		push_item(SAMPLE_MIN, 1'b1);
		push_item(SAMPLE_MAX, 1'b0);
		push_item(sample_t'(-1), 1'b0);
		// zero acts as one
		set_window(7'd0);
		push_item(sample_t'(7), 1'b0);
		push_item(sample_t'(-7), 1'b0);
		// shrinking the window mid-sequence: 5 samples held under a window
		// of 8, then a window of 4 gives a result on the very next sample
		set_window(7'd8);
		push_item(sample_t'(50), 1'b1);
		push_item(sample_t'(40), 1'b0);
		push_item(sample_t'(30), 1'b0);
		push_item(sample_t'(20), 1'b0);
		push_item(sample_t'(10), 1'b0);
		set_window(7'd4);
		push_item(sample_t'(5), 1'b0);
		directed_items = items_queued;

		// --- random phases ---
		phase = 0;
		while (items_queued < directed_items + RANDOM_ITEMS) begin
			if (phase < 10)
				next_win = WIN_PLAN[phase];
			else if ($urandom_range(0, 5) == 0)
				next_win = WIN_W'($urandom_range(13, 127));
			else
				next_win = WIN_W'($urandom_range(1, 12));

			// every fourth phase and the window-of-one phase run flat out
			// on both sides
			if (phase % 4 == 0 || phase == 1) begin
				src_burst_max = 64;
				src_gap_max   = 0;
				snk_mode      = SINK_ALWAYS;
			end else begin
				src_burst_max = $urandom_range(1, 16);
				src_gap_max   = ($urandom_range(0, 3) == 0) ? 24 : $urandom_range(1, 6);
				snk_mode      = sink_mode_t'($urandom_range(1, 2));
			end

			run_phase(next_win, (phase == 0) || ($urandom_range(0, 3) != 0));

			// window of one gives a result per sample: hold the output off
			// while the driver keeps offering, so the filter backs up
			if (phase == 1)
				hold_req++;
			phase++;
		end

		drain();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
